// ===== design/rau_pkg.sv =====
package rau_pkg;

   localparam int WORD_BITS = 32;
   localparam int MW        = WORD_BITS + 1;
   localparam int PW        = 2 * WORD_BITS;
   localparam int CW        = $clog2(PW);

   localparam logic [1:0] KIND_ADD = 2'd0;
   localparam logic [1:0] KIND_SUB = 2'd1;
   localparam logic [1:0] KIND_MUL = 2'd2;
   localparam logic [1:0] KIND_DIV = 2'd3;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_DIV0 = 2'd1;
   localparam logic [1:0] ST_OVF  = 2'd2;

   localparam logic [1:0] SP_NONE = 2'd0;
   localparam logic [1:0] SP_DIV0 = 2'd1;
   localparam logic [1:0] SP_ZERO = 2'd2;

   localparam logic [1:0] PH_0 = 2'd0;
   localparam logic [1:0] PH_1 = 2'd1;
   localparam logic [1:0] PH_2 = 2'd2;

   typedef struct packed {
      logic       load;
      logic       mul_en;
      logic [1:0] mul_phase;
      logic       prep;
      logic       gcd_step;
      logic       div_init;
      logic       div_step;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic special;
      logic gcd_done;
      logic div_last;
   } stat_type;

   typedef struct packed {
      logic [31:0] num;
      logic [30:0] den;
      logic        is_zero;
      logic        is_int;
      logic [1:0]  status;
   } res_type;

endpackage

// ===== design/rau_ctrl.sv =====
module rau_ctrl
   import rau_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  logic     out_free,
   input  stat_type stat,
   output logic     in_ready,
   output cmd_type  cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL0 = 3'd1;
   localparam logic [2:0] S_MUL1 = 3'd2;
   localparam logic [2:0] S_MUL2 = 3'd3;
   localparam logic [2:0] S_PREP = 3'd4;
   localparam logic [2:0] S_GCD  = 3'd5;
   localparam logic [2:0] S_DIV  = 3'd6;
   localparam logic [2:0] S_FIN  = 3'd7;

   logic [2:0] state_ff, state_in;

   assign in_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               cmd.load = 1'b1;
               state_in = stat.special ? S_FIN : S_MUL0;
            end
         end
         S_MUL0: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_phase = PH_0;
            state_in      = S_MUL1;
         end
         S_MUL1: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_phase = PH_1;
            state_in      = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_phase = PH_2;
            state_in      = S_PREP;
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = S_GCD;
         end
         S_GCD: begin
            if (stat.gcd_done) begin
               cmd.div_init = 1'b1;
               state_in     = S_DIV;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) state_in = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

// ===== design/rau_dp.sv =====
module rau_dp
   import rau_pkg::*;
(
   input  logic        clock,
   input  cmd_type     cmd,
   input  logic [1:0]  kind,
   input  logic [31:0] a_num,
   input  logic [30:0] a_den,
   input  logic [31:0] b_num,
   input  logic [30:0] b_den,
   output stat_type    stat,
   output res_type     res
);

   localparam logic [PW-1:0] LIM = PW'(1) << (WORD_BITS - 1);

   logic [1:0]          kind_ff;
   logic signed [MW-1:0] an_ff, ad_ff, bn_ff, bd_ff;
   logic signed [MW-1:0] an_in, ad_in, bn_in, bd_in;
   logic [1:0]          sp_ff, sp_in;
   logic signed [PW-1:0] p_ff, x_ff, n_ff;
   logic                neg_ff;
   logic [PW-1:0]       ga_ff, gb_ff, g_ff, num_ff, den_ff;
   logic [PW-1:0]       qa_ff, qb_ff, ra_ff, rb_ff;
   logic [CW-1:0]       k_ff, cnt_ff;

   logic signed [MW-1:0]   mul_a, mul_b;
   logic signed [2*MW-1:0] prod;
   logic signed [PW-1:0]   nn, dd;
   logic [PW-1:0]          mag;
   logic [PW:0]            ta, tb;
   logic [PW-1:0]          nv;

   assign an_in = MW'($signed(a_num[WORD_BITS-1:0]));
   assign bn_in = MW'($signed(b_num[WORD_BITS-1:0]));
   assign ad_in = MW'({1'b0, a_den[WORD_BITS-2:0]});
   assign bd_in = MW'({1'b0, b_den[WORD_BITS-2:0]});

   always_comb begin
      sp_in = SP_NONE;
      if (ad_in == '0 || bd_in == '0)                          sp_in = SP_DIV0;
      else if (kind == KIND_DIV && bn_in == '0)                sp_in = SP_DIV0;
      else if (kind == KIND_DIV && an_in == '0)                sp_in = SP_ZERO;
      else if (kind == KIND_MUL && (an_in == '0 || bn_in == '0)) sp_in = SP_ZERO;
   end

   // operand pairs per phase: the last phase gives the denominator
   always_comb begin
      mul_a = an_ff;
      mul_b = bd_ff;
      case (cmd.mul_phase)
         PH_0: begin
            mul_a = an_ff;
            mul_b = (kind_ff == KIND_MUL) ? bn_ff : bd_ff;
         end
         PH_1: begin
            if (kind_ff == KIND_MUL)      begin mul_a = an_ff; mul_b = bn_ff; end
            else if (kind_ff == KIND_DIV) begin mul_a = an_ff; mul_b = bd_ff; end
            else                          begin mul_a = bn_ff; mul_b = ad_ff; end
         end
         PH_2: begin
            mul_a = ad_ff;
            mul_b = (kind_ff == KIND_DIV) ? bn_ff : bd_ff;
         end
         default: begin
            mul_a = an_ff;
            mul_b = bd_ff;
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   always_comb begin
      nn  = p_ff[PW-1] ? -n_ff : n_ff;
      dd  = p_ff[PW-1] ? -p_ff : p_ff;
      mag = nn[PW-1] ? PW'(-nn) : PW'(nn);
   end

   assign ta = {ra_ff, qa_ff[PW-1]};
   assign tb = {rb_ff, qb_ff[PW-1]};

   assign stat.special  = (sp_in != SP_NONE);
   assign stat.gcd_done = (ga_ff == '0) || (gb_ff == '0);
   assign stat.div_last = (cnt_ff == CW'(PW - 1));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= kind;
         an_ff   <= an_in;
         ad_ff   <= ad_in;
         bn_ff   <= bn_in;
         bd_ff   <= bd_in;
         sp_ff   <= sp_in;
      end
      if (cmd.mul_en) begin
         p_ff <= prod[PW-1:0];
         x_ff <= p_ff;
         if (cmd.mul_phase == PH_2) begin
            case (kind_ff)
               KIND_ADD: n_ff <= x_ff + p_ff;
               KIND_SUB: n_ff <= x_ff - p_ff;
               default:  n_ff <= x_ff;
            endcase
         end
      end
      if (cmd.prep) begin
         neg_ff <= nn[PW-1];
         ga_ff  <= mag;
         gb_ff  <= PW'(dd);
         num_ff <= mag;
         den_ff <= PW'(dd);
         k_ff   <= '0;
      end
      // binary gcd, one step a cycle
      if (cmd.gcd_step) begin
         if (!ga_ff[0] && !gb_ff[0]) begin
            ga_ff <= ga_ff >> 1;
            gb_ff <= gb_ff >> 1;
            k_ff  <= k_ff + CW'(1);
         end else if (!ga_ff[0]) begin
            ga_ff <= ga_ff >> 1;
         end else if (!gb_ff[0]) begin
            gb_ff <= gb_ff >> 1;
         end else if (ga_ff >= gb_ff) begin
            ga_ff <= ga_ff - gb_ff;
         end else begin
            gb_ff <= gb_ff - ga_ff;
         end
      end
      if (cmd.div_init) begin
         g_ff   <= (ga_ff | gb_ff) << k_ff;
         qa_ff  <= num_ff;
         qb_ff  <= den_ff;
         ra_ff  <= '0;
         rb_ff  <= '0;
         cnt_ff <= '0;
      end
      // two restoring dividers sharing the divisor
      if (cmd.div_step) begin
         cnt_ff <= cnt_ff + CW'(1);
         if (ta >= {1'b0, g_ff}) begin
            ra_ff <= PW'(ta - {1'b0, g_ff});
            qa_ff <= {qa_ff[PW-2:0], 1'b1};
         end else begin
            ra_ff <= ta[PW-1:0];
            qa_ff <= {qa_ff[PW-2:0], 1'b0};
         end
         if (tb >= {1'b0, g_ff}) begin
            rb_ff <= PW'(tb - {1'b0, g_ff});
            qb_ff <= {qb_ff[PW-2:0], 1'b1};
         end else begin
            rb_ff <= tb[PW-1:0];
            qb_ff <= {qb_ff[PW-2:0], 1'b0};
         end
      end
   end

   assign nv = neg_ff ? (PW'(0) - qa_ff) : qa_ff;

   always_comb begin
      res.num     = '0;
      res.den     = 31'd1;
      res.is_zero = 1'b1;
      res.is_int  = 1'b1;
      res.status  = ST_OK;
      case (sp_ff)
         SP_DIV0: res.status = ST_DIV0;
         SP_ZERO: res.status = ST_OK;
         default: begin
            if (qb_ff > LIM - PW'(1) ||
                (neg_ff ? (qa_ff > LIM) : (qa_ff > LIM - PW'(1)))) begin
               res.is_zero = 1'b0;
               res.is_int  = 1'b0;
               res.status  = ST_OVF;
            end else begin
               res.num     = 32'($signed(nv[WORD_BITS-1:0]));
               res.den     = 31'(qb_ff[WORD_BITS-2:0]);
               res.is_zero = (qa_ff == '0);
               res.is_int  = (qb_ff == PW'(1));
            end
         end
      endcase
   end

endmodule

// ===== design/rational_arithmetic_unit_top.sv =====
// Rational arithmetic unit: adds, subtracts, multiplies or divides two fractions
// and returns the result reduced to lowest terms with a positive denominator.
// One word is worked on at a time. A word takes its products on one
// shared multiplier, a sign fixup, a binary gcd of one step a cycle over
// the 64-bit numerator and denominator, the forming of the gcd and a
// shift-and-subtract division of both by it, then the load of the output
// register, which waits until the output register is free.
// Zero operands in multiply or divide and division by zero skip straight
// from accept to the output register.
// A finished result waits in the output register while the next word is
// already taken.
module rational_arithmetic_unit_top
   import rau_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // a_num[31:0], a_den[62:32], b_num[94:63], b_den[125:95], zero pad
   input  logic [127:0] req_tdata,
   // kind[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // res_num[31:0], res_den[62:32], zero pad
   output logic [63:0]  rsp_tdata,
   // is_zero[0], is_integer[1], status[3:2]
   output logic [3:0]   rsp_tuser
);

   cmd_type  cmd;
   stat_type stat;
   res_type  res;
   logic     rsp_valid_ff;
   logic [63:0] rsp_data_ff;
   logic [3:0]  rsp_user_ff;
   logic     out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   rau_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .out_free (out_free),
      .stat     (stat),
      .in_ready (req_tready),
      .cmd      (cmd)
   );

   rau_dp u_dp (
      .clock (clock),
      .cmd   (cmd),
      .kind  (req_tuser),
      .a_num (req_tdata[31:0]),
      .a_den (req_tdata[62:32]),
      .b_num (req_tdata[94:63]),
      .b_den (req_tdata[125:95]),
      .stat  (stat),
      .res   (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff <= {1'b0, res.den, res.num};
         rsp_user_ff <= {res.status, res.is_int, res.is_zero};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== design/rau_checker.sv =====
module rau_port_checker
   import rau_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [127:0] req_tdata,
   input logic [1:0]   req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [63:0]  rsp_tdata,
   input logic [3:0]   rsp_tuser
);

   // a held result stays offered
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // error statuses always carry 0/1
   a_err_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[3:2] != ST_OK |->
         rsp_tdata[31:0] == 32'd0 && rsp_tdata[62:32] == 31'd1)
      else $error("error status with nonzero fraction");

   // flags agree with the fraction on a good result
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[3:2] == ST_OK |->
         rsp_tdata[62:32] != 31'd0 &&
         rsp_tuser[0] == (rsp_tdata[31:0] == 32'd0) &&
         rsp_tuser[1] == (rsp_tdata[62:32] == 31'd1))
      else $error("flags disagree with result");

   // one word in flight: no new word taken while busy after accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("word taken while busy");

endmodule

bind rational_arithmetic_unit_top rau_port_checker u_rau_checker (.*);
